[hdl/positional_array_list_defines.svh]
// Assertion macros for the positional array list.
// All of them sample on i_clk and are disabled while i_rst_n is low.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define PAL_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("positional_array_list: invariant violated");
`define PAL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional_array_list: same-cycle check failed");
`define PAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional_array_list: next-cycle check failed");
`else
`define PAL_ASSERT_ALWAYS(label, cond)
`define PAL_ASSERT_IMP(label, ante, cons)
`define PAL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/pal_pkg.sv]
package pal_pkg;

    // Field widths of one item.
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;

    // Request codes; the last code is reserved and answers with an error.
    typedef enum logic [1:0] {
        KIND_GET = 2'd0,
        KIND_INS = 2'd1,
        KIND_DEL = 2'd2,
        KIND_RSV = 2'd3
    } t_kind;

    // Shift commands broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

[hdl/pal_cell.sv]
module pal_cell #(
    parameter int INDEX = 0,
    parameter int TW    = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pal_pkg::t_cell_ctl                    i_ctl,
    input  logic [TW-1:0]                         i_target,
    input  logic signed [pal_pkg::DATA_W-1:0]     i_value,
    input  logic signed [pal_pkg::DATA_W-1:0]     i_left,
    input  logic signed [pal_pkg::DATA_W-1:0]     i_right,
    input  logic signed [pal_pkg::DATA_W-1:0]     i_bus,
    input  logic                                  i_bus_vld,
    output logic signed [pal_pkg::DATA_W-1:0]     o_data,
    output logic signed [pal_pkg::DATA_W-1:0]     o_bus,
    output logic                                  o_bus_vld
);

    localparam logic [TW-1:0] MY_IDX = TW'(INDEX);

    logic signed [pal_pkg::DATA_W-1:0] r_data;
    logic signed [pal_pkg::DATA_W-1:0] r_bus;
    logic                              r_bus_vld;
    logic                              w_hit;
    logic                              w_above;

    assign w_hit   = (i_target == MY_IDX);
    assign w_above = (MY_IDX > i_target);

    // Element storage: an insert opens a gap at the target, a delete closes it.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins && w_hit) begin
            r_data <= i_value;
        end else if (i_ctl.ins && w_above) begin
            r_data <= i_left;
        end else if (i_ctl.del && (w_hit || w_above)) begin
            r_data <= i_right;
        end
    end

    // Read wave: the selected cell drops its element onto the passing bus.
    always_ff @(posedge i_clk) begin
        r_bus <= w_hit ? r_data : i_bus;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_vld <= 1'b0;
        end else begin
            r_bus_vld <= i_bus_vld;
        end
    end

    assign o_data    = r_data;
    assign o_bus     = r_bus;
    assign o_bus_vld = r_bus_vld;

endmodule

[hdl/positional_array_list.sv]
// An insert or any request that fails moves straight to the output state after acceptance.
// A get or a delete first sends the read wave along the chain of cells and gives its result
// when the wave leaves the last cell. One item is in work at a time; the next one is
// taken in the cycle after the result is delivered.
// Reset (synchronous, active low) empties the list, returns the sequencer to idle and clears
// the valid bits of the read wave; the element cells and the other registers are not cleared.
module positional_array_list #(
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_kind,
    input  logic [pal_pkg::POS_W-1:0]             i_position,
    input  logic signed [pal_pkg::DATA_W-1:0]     i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_status,
    output logic signed [pal_pkg::DATA_W-1:0]     o_element,
    output logic [pal_pkg::POS_W-1:0]             o_count
);

`include "positional_array_list_defines.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [EW-1:0]                      r_target, n_target;
    logic                               r_is_del, n_is_del;
    logic                               r_status, n_status;
    logic signed [pal_pkg::DATA_W-1:0]  r_element, n_element;
    logic [pal_pkg::POS_W-1:0]          r_out_count, n_out_count;

    logic                               w_accept;
    logic                               w_start;
    logic [EW:0]                        w_pos;
    logic [EW:0]                        w_cnt;
    logic                               w_rd_ok;
    logic                               w_ins_ok;
    logic [EW-1:0]                      w_target;
    pal_pkg::t_cell_ctl                 w_ctl;

    logic signed [pal_pkg::DATA_W-1:0]  w_data [DEPTH];
    logic signed [pal_pkg::DATA_W-1:0]  w_bus  [DEPTH+1];
    logic                               w_vld  [DEPTH+1];

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    // Position checks against the current length.
    assign w_pos    = (EW + 1)'(i_position);
    assign w_cnt    = (EW + 1)'(r_count);
    assign w_rd_ok  = (i_position != '0) && (w_pos <= w_cnt);
    assign w_ins_ok = (r_count < FULL) && (i_position != '0) && (w_pos <= w_cnt + 1'b1);

    // The target comes straight from the item while idle, from its copy afterwards.
    assign w_target = (r_state == S_IDLE) ? EW'(w_pos - 1'b1) : r_target;

    assign w_start = w_accept && w_rd_ok &&
                     ((i_kind == pal_pkg::KIND_GET) || (i_kind == pal_pkg::KIND_DEL));

    // Sequencer for one item at a time.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_target    = r_target;
        n_is_del    = r_is_del;
        n_status    = r_status;
        n_element   = r_element;
        n_out_count = r_out_count;
        w_ctl       = '{ins: 1'b0, del: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_target  = w_target;
                    n_is_del  = (i_kind == pal_pkg::KIND_DEL);
                    n_status  = 1'b1;
                    n_element = '0;
                    n_state   = S_OUT;
                    if (w_start) begin
                        n_state = S_SCAN;
                    end else if ((i_kind == pal_pkg::KIND_INS) && w_ins_ok) begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                        n_status  = 1'b0;
                    end
                    n_out_count = pal_pkg::POS_W'(EW'(n_count));
                end
            end
            S_SCAN: begin
                if (w_vld[DEPTH]) begin
                    n_element = w_bus[DEPTH];
                    n_status  = 1'b0;
                    if (r_is_del) begin
                        w_ctl.del = 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                    n_out_count = pal_pkg::POS_W'(EW'(n_count));
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_is_del    <= n_is_del;
        r_status    <= n_status;
        r_element   <= n_element;
        r_out_count <= n_out_count;
    end

    assign o_valid   = (r_state == S_OUT);
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_count   = r_out_count;

    // Row of element cells; the read wave enters at the first cell.
    assign w_bus[0] = '0;
    assign w_vld[0] = w_start;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [pal_pkg::DATA_W-1:0] w_left;
        logic signed [pal_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end
        pal_cell #(
            .INDEX (g),
            .TW    (EW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_target  (w_target),
            .i_value   (i_value),
            .i_left    (w_left),
            .i_right   (w_right),
            .i_bus     (w_bus[g]),
            .i_bus_vld (w_vld[g]),
            .o_data    (w_data[g]),
            .o_bus     (w_bus[g+1]),
            .o_bus_vld (w_vld[g+1])
        );
    end

    // Checks on the sequencer and the read wave.
    `PAL_ASSERT_ALWAYS(a_count_bound, r_count <= FULL)
    `PAL_ASSERT_IMP(a_wave_in_scan, w_vld[DEPTH], r_state == S_SCAN)
    `PAL_ASSERT_NEXT(a_accept_moves, w_accept, (r_state == S_SCAN) || (r_state == S_OUT))
    `PAL_ASSERT_IMP(a_error_zero, o_valid && o_status, o_element == '0)

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH   = 32;
    localparam int          RANDOM_ITEMS = 400;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    // One response as the list should report it.
    typedef struct {
        logic                              status;
        logic signed [pal_pkg::DATA_W-1:0] element;
        logic [pal_pkg::POS_W-1:0]         count;
    } t_list_response;

    // Shadow copy of the list; it predicts each response and checks the ones that arrive.
    class t_list_shadow;
        logic signed [pal_pkg::DATA_W-1:0] cells [LIST_DEPTH];
        int                                length;
        t_list_response                    pending [$];
        int                                errors;

        function new();
            length = 0;
            errors = 0;
        endfunction

        // Applies one accepted request to the shadow list and queues its response.
        function void note_request(logic [1:0] kind, logic [pal_pkg::POS_W-1:0] pos,
                                   logic signed [pal_pkg::DATA_W-1:0] val);
            t_list_response rsp;
            int             p;
            rsp.status  = 1'b1;
            rsp.element = '0;
            p = int'(pos);
            case (kind)
                pal_pkg::KIND_GET: begin
                    if (p >= 1 && p <= length) begin
                        rsp.status  = 1'b0;
                        rsp.element = cells[p-1];
                    end
                end
                pal_pkg::KIND_INS: begin
                    if (length < LIST_DEPTH && p >= 1 && p <= length + 1) begin
                        for (int k = length; k > p - 1; k--)
                            cells[k] = cells[k-1];
                        cells[p-1] = val;
                        length++;
                        rsp.status = 1'b0;
                    end
                end
                pal_pkg::KIND_DEL: begin
                    if (p >= 1 && p <= length) begin
                        rsp.element = cells[p-1];
                        for (int k = p - 1; k + 1 < length; k++)
                            cells[k] = cells[k+1];
                        length--;
                        rsp.status = 1'b0;
                    end
                end
                default: ;
            endcase
            rsp.count = pal_pkg::POS_W'(length);
            pending.push_back(rsp);
        endfunction

        // Compares one delivered response with the oldest prediction.
        function void check_response(logic status, logic signed [pal_pkg::DATA_W-1:0] element,
                                     logic [pal_pkg::POS_W-1:0] count);
            t_list_response want;
            if (pending.size() == 0) begin
                $error("response without a request: status %0d element %0d count %0d",
                       status, element, count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (element !== want.element) begin
                $error("element: expected %0d, actual %0d", want.element, element);
                errors++;
            end
            if (count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic [1:0]                        i_kind;
    logic [pal_pkg::POS_W-1:0]         i_position;
    logic signed [pal_pkg::DATA_W-1:0] i_value;
    logic                              o_valid;
    logic                              i_stall;
    logic                              o_status;
    logic signed [pal_pkg::DATA_W-1:0] o_element;
    logic [pal_pkg::POS_W-1:0]         o_count;

    t_list_shadow shadow = new();
    bit           calm = 1'b0;
    int unsigned  cycle_count = 0;
    int unsigned  stall_left = 0;

    positional_array_list #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_kind    (i_kind),
        .i_position(i_position),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_element (o_element),
        .o_count   (o_count)
    );

    // Clock and reset.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Gap length for either side: mostly short, a few long, none during calm stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Presents one item, holds it until it is taken, then idles for a random gap.
    task automatic send_item(logic [1:0] kind, logic [pal_pkg::POS_W-1:0] pos,
                             logic signed [pal_pkg::DATA_W-1:0] val);
        int unsigned gap;
        i_valid    = 1'b1;
        i_kind     = kind;
        i_position = pos;
        i_value    = val;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        shadow.note_request(kind, pos, val);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid    = 1'b0;
            i_kind     = 2'($urandom);
            i_position = pal_pkg::POS_W'($urandom);
            i_value    = $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Receiver stalls in bursts of random length.
    initial i_stall = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
            stall_left = pick_gap();
        end
    end

    // Every response taken at a rising edge is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            shadow.check_response(o_status, o_element, o_count);
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [1:0]                kind;
        logic [pal_pkg::POS_W-1:0] pos;
        int unsigned               len;
        int unsigned               roll;
        bit                        filling;

        i_valid    = 1'b0;
        i_kind     = pal_pkg::KIND_GET;
        i_position = '0;
        i_value    = '0;
        filling    = 1'b1;
        @(posedge i_rst_n);
        @(negedge i_clk);

        // Requests on an empty list and bad insert positions.
        send_item(pal_pkg::KIND_GET, 6'd1, 32'sd5);
        send_item(pal_pkg::KIND_DEL, 6'd1, 32'sd5);
        send_item(pal_pkg::KIND_INS, 6'd0, 32'sd7);
        send_item(pal_pkg::KIND_INS, 6'd2, 32'sd7);
        // Build -1, 0, max, min with inserts at front, middle and end.
        send_item(pal_pkg::KIND_INS, 6'd1, 32'sh7FFFFFFF);
        send_item(pal_pkg::KIND_INS, 6'd2, 32'sh80000000);
        send_item(pal_pkg::KIND_INS, 6'd1, -32'sd1);
        send_item(pal_pkg::KIND_INS, 6'd2, 32'sd0);
        // Gets, inserts and a delete at and beyond the edges, and the unused request code.
        send_item(pal_pkg::KIND_GET, 6'd0, 32'sd0);
        send_item(pal_pkg::KIND_GET, 6'd4, 32'sd0);
        send_item(pal_pkg::KIND_GET, 6'd5, 32'sd0);
        send_item(pal_pkg::KIND_GET, 6'd63, 32'sd0);
        send_item(pal_pkg::KIND_RSV, 6'd1, 32'sh5A5A5A5A);
        send_item(pal_pkg::KIND_INS, 6'd6, 32'sd9);
        send_item(pal_pkg::KIND_INS, 6'd63, 32'sd9);
        send_item(pal_pkg::KIND_DEL, 6'd5, 32'sd0);
        // Deletes in the middle, at the end and at the front.
        send_item(pal_pkg::KIND_DEL, 6'd2, 32'sd0);
        send_item(pal_pkg::KIND_DEL, 6'd3, 32'sd0);
        send_item(pal_pkg::KIND_DEL, 6'd1, 32'sd0);
        send_item(pal_pkg::KIND_GET, 6'd1, 32'sd0);
        send_item(pal_pkg::KIND_INS, 6'd2, 32'sh55555555);
        send_item(pal_pkg::KIND_DEL, 6'd0, 32'sd0);
        send_item(pal_pkg::KIND_DEL, 6'd1, 32'sd0);
        send_item(pal_pkg::KIND_DEL, 6'd1, 32'sd0);

        // Random part: the list swings between empty and full, mostly with valid positions.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            len = shadow.length;
            if (filling && len == LIST_DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && len == 0 && $urandom_range(0, 1) == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                kind = 2'($urandom_range(0, 3));
            else if (filling)
                kind = (roll < 70) ? pal_pkg::KIND_INS :
                       ((roll < 88) ? pal_pkg::KIND_GET : pal_pkg::KIND_DEL);
            else
                kind = (roll < 65) ? pal_pkg::KIND_DEL :
                       ((roll < 85) ? pal_pkg::KIND_GET : pal_pkg::KIND_INS);
            if ($urandom_range(0, 99) < 12)
                pos = pal_pkg::POS_W'($urandom_range(0, 63));
            else if (kind == pal_pkg::KIND_INS)
                pos = pal_pkg::POS_W'($urandom_range(1, len + 1));
            else
                pos = (len == 0) ? 6'd1 : pal_pkg::POS_W'($urandom_range(1, len));
            send_item(kind, pos, $urandom);
        end
        i_valid = 1'b0;

        // Drain, then watch for stray responses.
        while (shadow.pending.size() != 0)
            @(posedge i_clk);
        repeat (LIST_DEPTH + 4) @(posedge i_clk);
        if (shadow.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
